// File: rtl/hmsha_pkg.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine package
// Shared types, SHA-1 constants and byte lane helpers for the engine.
// ----------------------------------------------------------------------------
package hmsha_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0] byte_t;

	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hEFCDAB89;
	localparam word_t IV2 = 32'h98BADCFE;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hC3D2E1F0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam byte_t IPAD  = 8'h36;
	localparam byte_t OPAD  = 8'h5C;
	localparam byte_t PAD80 = 8'h80;

	localparam logic [1:0] CMD_KEY = 2'd0;
	localparam logic [1:0] CMD_EOK = 2'd1;
	localparam logic [1:0] CMD_MSG = 2'd2;
	localparam logic [1:0] CMD_EOM = 2'd3;

	localparam int unsigned ROUNDS = 80;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = IV0;
			3'd1: r = IV1;
			3'd2: r = IV2;
			3'd3: r = IV3;
			default: r = IV4;
		endcase
		return r;
	endfunction

	function automatic byte_t byte_get(input word_t w, input logic [1:0] sel);
		byte_t r;
		unique case (sel)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

	function automatic word_t byte_put(input word_t w, input logic [1:0] sel,
	                                   input byte_t b);
		word_t r;
		r = w;
		unique case (sel)
			2'd0: r[31:24] = b;
			2'd1: r[23:16] = b;
			2'd2: r[15:8] = b;
			default: r[7:0] = b;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/hmsha_core.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 compression core
// One SHA-1 round per cycle over a sixteen word shifting schedule window.
// ----------------------------------------------------------------------------
module hmsha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hmsha_pkg::word_t    block_words [16],
	input  hmsha_pkg::word_t    chain_in [5],
	output logic                done,
	output hmsha_pkg::word_t    vars_out [5]
);
	import hmsha_pkg::*;

	word_t w_q [16];
	word_t v_q [5];
	logic [6:0] rnd_q;
	logic run_q;
	logic done_q;
	word_t f, k, t, wn, x;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = v_q[3] ^ (v_q[1] & (v_q[2] ^ v_q[3]));
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (v_q[1] & v_q[2]) | (v_q[3] & (v_q[1] | v_q[2]));
			k = K2;
		end else begin
			f = v_q[1] ^ v_q[2] ^ v_q[3];
			k = K3;
		end
		t = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + w_q[0] + k;
		x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wn = {x[30:0], x[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'(ROUNDS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= block_words;
			v_q <= chain_in;
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wn;
			v_q[4] <= v_q[3];
			v_q[3] <= v_q[2];
			v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
			v_q[1] <= v_q[0];
			v_q[0] <= t;
		end
	end

	assign done = done_q;
	assign vars_out = v_q;

endmodule

// File: rtl/hmac_sha1_engine_unit.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine
// Keyed SHA-1 message authentication over a byte stream.
// ----------------------------------------------------------------------------
// Each input word carries a command in tuser and a byte in tdata. Key bytes
// come first and are closed by an end-of-key word; message bytes follow and
// are closed by an end-of-message word. The block then returns five digest
// words on the output channel, word 0 first, with tlast on the fifth.
// Key and message bytes are accepted one per cycle while the input is ready,
// and every 64th absorbed byte starts the compression core, which runs one
// round per cycle. Closing a key of up to 64 bytes absorbs the inner pad and
// runs one compression; a longer key is first hashed with padding and its
// digest serves as the key. End of message, before the first digest word,
// absorbs the padding, the outer pad block, the inner digest and the final
// padding, one byte per cycle between three or four compressions.
// The input is not ready while any of this work runs or while digest words
// wait; a stalled receiver simply holds the current digest word.
// After the fifth word is taken the block returns to its reset state with
// the key cleared. Reset takes effect at once and needs no clearing pass.
// ----------------------------------------------------------------------------
module hmac_sha1_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_value
	input  logic [1:0]  s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // digest_word
	output logic [2:0]  m_axis_tuser,   // word_index
	output logic        m_axis_tlast    // last_word
);
	import hmsha_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DUMP  = 8'b0000_0010,
		S_IPAD  = 8'b0000_0100,
		S_OPAD  = 8'b0000_1000,
		S_INNER = 8'b0001_0000,
		S_PAD   = 8'b0010_0000,
		S_COMP  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		J_KEY   = 3'b001,
		J_INNER = 3'b010,
		J_OUTER = 3'b100
	} job_t;

	state_t st_q, ret_q;
	job_t job_q;
	logic msg_q;
	logic long_q;
	logic [6:0] seen_q;
	logic [6:0] cnt_q;
	logic [2:0] oidx_q;
	logic [63:0] bc_q;
	logic [63:0] bits_q;
	logic start_q;
	byte_t held_q;
	word_t chain_q [5];
	word_t key_q [16];
	word_t blk_q [16];
	word_t inner_q [5];
	word_t vars [5];
	logic core_done;

	logic in_acc, out_acc, abs_en, blk_full, len_byte;
	byte_t abs_byte, key_byte;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (st_q == S_IDLE);
	assign m_axis_tvalid = (st_q == S_OUT);
	assign m_axis_tdata = chain_q[oidx_q];
	assign m_axis_tuser = oidx_q;
	assign m_axis_tlast = (oidx_q == 3'd4);
	assign key_byte = byte_get(key_q[cnt_q[5:2]], cnt_q[1:0]);
	assign len_byte = (st_q == S_PAD) && ((cnt_q >= 7'd2 && cnt_q <= 7'd8) ||
	                  (cnt_q == 7'd1 && bc_q[5:0] == 6'd56));

	always_comb begin
		abs_en = 1'b0;
		abs_byte = '0;
		unique case (st_q)
			S_IDLE: begin
				if (in_acc && ((!msg_q && s_axis_tuser == CMD_KEY && long_q) ||
				               (msg_q && s_axis_tuser == CMD_MSG))) begin
					abs_en = 1'b1;
					abs_byte = s_axis_tdata;
				end
			end
			S_DUMP: begin
				if (!cnt_q[6]) begin
					abs_en = 1'b1;
					abs_byte = key_byte;
				end else if (cnt_q == 7'd64) begin
					abs_en = 1'b1;
					abs_byte = held_q;
				end
			end
			S_IPAD: begin
				abs_en = !cnt_q[6];
				abs_byte = key_byte ^ IPAD;
			end
			S_OPAD: begin
				abs_en = !cnt_q[6];
				abs_byte = key_byte ^ OPAD;
			end
			S_INNER: begin
				abs_en = (cnt_q < 7'd20);
				abs_byte = byte_get(inner_q[cnt_q[4:2]], cnt_q[1:0]);
			end
			S_PAD: begin
				if (cnt_q == 7'd0) begin
					abs_en = 1'b1;
					abs_byte = PAD80;
				end else if (len_byte) begin
					abs_en = 1'b1;
					abs_byte = bits_q[63:56];
				end else if (cnt_q == 7'd1) begin
					abs_en = 1'b1;
				end
			end
			default: begin
				abs_en = 1'b0;
			end
		endcase
	end

	assign blk_full = abs_en && (bc_q[5:0] == 6'd63);

	hmsha_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.block_words(blk_q),
		.chain_in(chain_q),
		.done(core_done),
		.vars_out(vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			job_q <= J_KEY;
			msg_q <= 1'b0;
			long_q <= 1'b0;
			seen_q <= '0;
			cnt_q <= '0;
			oidx_q <= '0;
			bc_q <= '0;
			start_q <= 1'b0;
			for (int i = 0; i < 5; i++) chain_q[i] <= iv_word(3'(i));
			for (int i = 0; i < 16; i++) key_q[i] <= '0;
		end else begin
			start_q <= blk_full;
			if (abs_en) bc_q <= bc_q + 64'd1;
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!msg_q) begin
							if (s_axis_tuser == CMD_KEY && !long_q) begin
								if (!seen_q[6]) begin
									key_q[seen_q[5:2]] <= byte_put(key_q[seen_q[5:2]],
										seen_q[1:0], s_axis_tdata);
									seen_q <= seen_q + 7'd1;
								end else begin
									long_q <= 1'b1;
									for (int i = 0; i < 5; i++) chain_q[i] <= iv_word(3'(i));
									bc_q <= '0;
									cnt_q <= '0;
									st_q <= S_DUMP;
								end
							end else if (s_axis_tuser == CMD_EOK) begin
								cnt_q <= '0;
								if (long_q) begin
									job_q <= J_KEY;
									st_q <= S_PAD;
								end else begin
									for (int i = 0; i < 5; i++) chain_q[i] <= iv_word(3'(i));
									bc_q <= '0;
									st_q <= S_IPAD;
								end
							end
						end else if (s_axis_tuser == CMD_EOM) begin
							cnt_q <= '0;
							job_q <= J_INNER;
							st_q <= S_PAD;
						end
					end
				end
				S_DUMP: begin
					if (cnt_q == 7'd65) st_q <= S_IDLE;
					else cnt_q <= cnt_q + 7'd1;
				end
				S_IPAD: begin
					if (cnt_q[6]) begin
						msg_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_OPAD: begin
					if (cnt_q[6]) begin
						cnt_q <= '0;
						st_q <= S_INNER;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_INNER: begin
					if (cnt_q == 7'd20) begin
						cnt_q <= '0;
						job_q <= J_OUTER;
						st_q <= S_PAD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_PAD: begin
					if (cnt_q == 7'd9) begin
						cnt_q <= '0;
						unique case (job_q)
							J_KEY: begin
								for (int i = 0; i < 16; i++) begin
									key_q[i] <= (i < 5) ? chain_q[i % 5] : '0;
								end
								for (int i = 0; i < 5; i++) chain_q[i] <= iv_word(3'(i));
								bc_q <= '0;
								st_q <= S_IPAD;
							end
							J_INNER: begin
								for (int i = 0; i < 5; i++) chain_q[i] <= iv_word(3'(i));
								bc_q <= '0;
								st_q <= S_OPAD;
							end
							default: begin
								oidx_q <= '0;
								st_q <= S_OUT;
							end
						endcase
					end else if (cnt_q != 7'd1 || len_byte) begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				S_COMP: begin
					if (core_done) begin
						for (int i = 0; i < 5; i++) chain_q[i] <= chain_q[i] + vars[i];
						st_q <= ret_q;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (oidx_q == 3'd4) begin
							for (int i = 0; i < 5; i++) chain_q[i] <= iv_word(3'(i));
							for (int i = 0; i < 16; i++) key_q[i] <= '0;
							seen_q <= '0;
							long_q <= 1'b0;
							msg_q <= 1'b0;
							bc_q <= '0;
							oidx_q <= '0;
							st_q <= S_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
			if (blk_full) begin
				ret_q <= st_q;
				st_q <= S_COMP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (abs_en) blk_q[bc_q[5:2]] <= byte_put(blk_q[bc_q[5:2]], bc_q[1:0], abs_byte);
		if (st_q == S_IDLE && in_acc) held_q <= s_axis_tdata;
		if (st_q == S_PAD && cnt_q == 7'd0) bits_q <= {bc_q[60:0], 3'b000};
		else if (len_byte) bits_q <= {bits_q[55:0], 8'h00};
		if (st_q == S_PAD && cnt_q == 7'd9 && job_q == J_INNER) inner_q <= chain_q;
	end

	a_start_comp: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> st_q == S_COMP)
		else $error("compression started outside the compression state");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while digest words are pending");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 3'd4)
		else $error("last word flag on the wrong digest word");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
		else $error("digest word index did not advance");

endmodule
